### sv/vcfm_pkg.sv
// shared types, constants and microcode for the voxel chunk face mesher
package vcfm_pkg;

  // chunk geometry
  localparam int CHUNK_SIDE   = 16;
  localparam int CHUNK_LAYERS = 16;
  localparam int STORE_SIZE   = CHUNK_SIDE * CHUNK_SIDE * CHUNK_LAYERS;
  localparam int ADDR_W       = $clog2(STORE_SIZE);

  // field widths
  localparam int KIND_W  = 2;
  localparam int COORD_W = 4;
  localparam int TYPE_W  = 3;
  localparam int VERT_W  = 5;
  localparam int NORM_W  = 3;
  localparam int TEXU_W  = 3;
  localparam int TOTAL_W = 15;

  localparam int NUM_FACES   = 6;
  localparam int NUM_CORNERS = 6;
  localparam int FACE_W      = $clog2(NUM_FACES);
  localparam int CORNER_W    = $clog2(NUM_CORNERS);
  localparam int CNT_W       = $clog2(NUM_FACES + 1);

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  typedef logic [NUM_FACES-1:0] mask_t;

  // request kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD  = 2'd0,
    KIND_EMIT  = 2'd1,
    KIND_COUNT = 2'd2
  } kind_e;

  // read directions, faces first in emit order, then the voxel itself
  typedef enum logic [2:0] {
    DIR_NZ  = 3'd0,
    DIR_PZ  = 3'd1,
    DIR_PX  = 3'd2,
    DIR_NX  = 3'd3,
    DIR_PY  = 3'd4,
    DIR_NY  = 3'd5,
    DIR_CTR = 3'd6
  } dir_e;

  // sequencer jump kinds
  typedef enum logic [2:0] {
    JMP_NEXT     = 3'd0,
    JMP_DISPATCH = 3'd1,
    JMP_DECIDE   = 3'd2,
    JMP_EMIT     = 3'd3,
    JMP_RESULT   = 3'd4
  } jmp_e;

  localparam int STEP_W = 4;
  typedef logic [STEP_W-1:0] step_t;

  localparam step_t STEP_IDLE   = 4'd0;
  localparam step_t STEP_PROBE  = 4'd1;
  localparam step_t STEP_DECIDE = 4'd8;
  localparam step_t STEP_EMIT   = 4'd9;
  localparam step_t STEP_RESULT = 4'd10;

  // one control word per step
  typedef struct packed {
    logic  rd_en;
    dir_e  rd_dir;
    logic  cap_en;
    dir_e  cap_dir;
    jmp_e  jmp;
    step_t tgt;
  } ctrl_t;

  // microcode rom: probe the voxel and its six neighbors, then decide
  function automatic ctrl_t ucode(step_t s);
    ctrl_t w;
    w = '{rd_en: 1'b0, rd_dir: DIR_CTR, cap_en: 1'b0, cap_dir: DIR_CTR,
          jmp: JMP_DISPATCH, tgt: STEP_PROBE};
    case (s)
      4'd0:  w = '{1'b0, DIR_CTR, 1'b0, DIR_CTR, JMP_DISPATCH, STEP_PROBE};
      4'd1:  w = '{1'b1, DIR_CTR, 1'b0, DIR_CTR, JMP_NEXT,     STEP_IDLE};
      4'd2:  w = '{1'b1, DIR_NZ,  1'b1, DIR_CTR, JMP_NEXT,     STEP_IDLE};
      4'd3:  w = '{1'b1, DIR_PZ,  1'b1, DIR_NZ,  JMP_NEXT,     STEP_IDLE};
      4'd4:  w = '{1'b1, DIR_PX,  1'b1, DIR_PZ,  JMP_NEXT,     STEP_IDLE};
      4'd5:  w = '{1'b1, DIR_NX,  1'b1, DIR_PX,  JMP_NEXT,     STEP_IDLE};
      4'd6:  w = '{1'b1, DIR_PY,  1'b1, DIR_NX,  JMP_NEXT,     STEP_IDLE};
      4'd7:  w = '{1'b1, DIR_NY,  1'b1, DIR_PY,  JMP_NEXT,     STEP_IDLE};
      4'd8:  w = '{1'b0, DIR_CTR, 1'b1, DIR_NY,  JMP_DECIDE,   STEP_PROBE};
      4'd9:  w = '{1'b0, DIR_CTR, 1'b0, DIR_CTR, JMP_EMIT,     STEP_IDLE};
      4'd10: w = '{1'b0, DIR_CTR, 1'b0, DIR_CTR, JMP_RESULT,   STEP_IDLE};
      default: w = '{1'b0, DIR_CTR, 1'b0, DIR_CTR, JMP_DISPATCH, STEP_PROBE};
    endcase
    return w;
  endfunction

  // per vertex: bit0 x offset, bit1 y offset, bit2 z offset, bit3 u right, bit4 v
  localparam logic [4:0] CORNER_TAB [NUM_FACES][NUM_CORNERS] = '{
    '{5'h18, 5'h03, 5'h11, 5'h18, 5'h0A, 5'h03},
    '{5'h1C, 5'h15, 5'h07, 5'h1C, 5'h07, 5'h0E},
    '{5'h15, 5'h19, 5'h0B, 5'h15, 5'h0B, 5'h07},
    '{5'h1C, 5'h02, 5'h10, 5'h1C, 5'h0E, 5'h02},
    '{5'h02, 5'h1F, 5'h0B, 5'h02, 5'h16, 5'h1F},
    '{5'h00, 5'h09, 5'h1D, 5'h00, 5'h1D, 5'h14}
  };

  // linear store address, layer major
  function automatic logic [ADDR_W-1:0] addr_of(logic [COORD_W-1:0] h,
                                                logic [COORD_W-1:0] v,
                                                logic [COORD_W-1:0] d);
    return ADDR_W'(d) * ADDR_W'(CHUNK_SIDE * CHUNK_SIDE)
         + ADDR_W'(v) * ADDR_W'(CHUNK_SIDE)
         + ADDR_W'(h);
  endfunction

  // coordinate inside the chunk
  function automatic logic in_chunk(logic [COORD_W-1:0] h,
                                    logic [COORD_W-1:0] v,
                                    logic [COORD_W-1:0] d);
    return (32'(h) < CHUNK_SIDE) && (32'(v) < CHUNK_SIDE) && (32'(d) < CHUNK_LAYERS);
  endfunction

endpackage

### sv/vcfm_ram.sv
// generic single write port ram with registered read
module vcfm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### sv/voxel_chunk_face_mesher_core.sv
// voxel chunk face mesher: microcoded sequencer over one voxel store
//
//   channel  direction  handshake               payload
//   in       input      in_valid_i/in_ready_o   kind, pos_h, pos_v, pos_d, block_type
//   out      output     out_valid_o/out_ready_i vert xyz, normal, tex uv, flags, total
//
// a load is written to the store when accepted; a mesh request, after acceptance, probes (seven
// store reads for the voxel and its neighbors, then a decide step) and then gives one beat
// per cycle while the output is not stalled, up to 36 vertex beats.
// a count request probes every voxel in turn, one after another, limited by the single
// read port of the voxel store.
// reset returns the sequencer to idle and empties the output register; the voxel
// store keeps no reset and holds garbage until loaded.
// a stalled output beat holds the sequencer; new requests are taken only while idle.
module voxel_chunk_face_mesher_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [vcfm_pkg::KIND_W-1:0]   kind_i,
  input  logic [vcfm_pkg::COORD_W-1:0]  pos_h_i,
  input  logic [vcfm_pkg::COORD_W-1:0]  pos_v_i,
  input  logic [vcfm_pkg::COORD_W-1:0]  pos_d_i,
  input  logic signed [vcfm_pkg::TYPE_W-1:0] block_type_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [vcfm_pkg::VERT_W-1:0]   vert_x_o,
  output logic [vcfm_pkg::VERT_W-1:0]   vert_y_o,
  output logic [vcfm_pkg::VERT_W-1:0]   vert_z_o,
  output logic [vcfm_pkg::NORM_W-1:0]   normal_code_o,
  output logic [vcfm_pkg::TEXU_W-1:0]   tex_u_o,
  output logic                          tex_v_o,
  output logic                          has_vertex_o,
  output logic [vcfm_pkg::TOTAL_W-1:0]  face_total_o,
  output logic                          last_o
);
  import vcfm_pkg::*;

  // sequencer
  step_t step_q, step_d;
  ctrl_t ctrl;
  kind_e mode_q, mode_d;

  // working voxel position, also the scan counters of a count
  logic [COORD_W-1:0] h_q, h_d, v_q, v_d, d_q, d_d;

  // probe results
  logic               solid_q, solid_d;
  logic [1:0]         type_q, type_d;
  mask_t              open_q, open_d;
  mask_t              faces;
  logic               rd_open;

  // emit and count state
  mask_t              emit_q, emit_d, emit_rest;
  logic [CORNER_W-1:0] k_q, k_d;
  logic [FACE_W-1:0]  face_sel;
  logic [4:0]         corner;
  logic [TOTAL_W-1:0] total_q, total_d;
  logic [TOTAL_W:0]   total_sum;
  logic [CNT_W-1:0]   face_cnt;
  logic               scan_last;

  // store ports
  logic               we;
  logic [ADDR_W-1:0]  waddr, rd_addr;
  logic [TYPE_W-1:0]  rdata;
  logic [COORD_W-1:0] nh, nv, nd;
  logic               rd_ok, rd_ok_q;

  // output register
  logic               slot_free, push;
  logic               out_valid_q, out_valid_d;
  logic [VERT_W-1:0]  vx_d, vy_d, vz_d, vx_q, vy_q, vz_q;
  logic [NORM_W-1:0]  norm_d, norm_q;
  logic [TEXU_W-1:0]  tu_d, tu_q;
  logic               tv_d, tv_q, hv_d, hv_q, last_d, last_q;
  logic [TOTAL_W-1:0] tot_d, tot_q;

  assign ctrl = ucode(step_q);

  // voxel store
  vcfm_ram #(
    .WIDTH (TYPE_W),
    .DEPTH (STORE_SIZE)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (block_type_i),
    .raddr_i (rd_addr),
    .rdata_o (rdata)
  );

  assign waddr = addr_of(pos_h_i, pos_v_i, pos_d_i);

  // neighbor address and range check for the read of this step
  always_comb begin
    nh    = h_q;
    nv    = v_q;
    nd    = d_q;
    rd_ok = ctrl.rd_en && in_chunk(h_q, v_q, d_q);
    case (ctrl.rd_dir)
      DIR_NZ: begin
        nv    = v_q - 1'b1;
        rd_ok = rd_ok && (v_q != '0);
      end
      DIR_PZ: begin
        nv    = v_q + 1'b1;
        rd_ok = rd_ok && (32'(v_q) < CHUNK_SIDE - 1);
      end
      DIR_PX: begin
        nh    = h_q + 1'b1;
        rd_ok = rd_ok && (32'(h_q) < CHUNK_SIDE - 1);
      end
      DIR_NX: begin
        nh    = h_q - 1'b1;
        rd_ok = rd_ok && (h_q != '0);
      end
      DIR_PY: begin
        nd    = d_q + 1'b1;
        rd_ok = rd_ok && (32'(d_q) < CHUNK_LAYERS - 1);
      end
      DIR_NY: begin
        nd    = d_q - 1'b1;
        rd_ok = rd_ok && (d_q != '0);
      end
      default: begin
        nh = h_q;
      end
    endcase
    rd_addr = addr_of(nh, nv, nd);
  end

  // capture of the read issued one step earlier
  always_comb begin
    rd_open = !rd_ok_q || rdata[TYPE_W-1];
    open_d  = open_q;
    solid_d = solid_q;
    type_d  = type_q;
    if (ctrl.cap_en) begin
      if (ctrl.cap_dir == DIR_CTR) begin
        solid_d = !rd_open;
        type_d  = rdata[1:0];
      end else begin
        open_d[ctrl.cap_dir[FACE_W-1:0]] = rd_open;
      end
    end
    faces = open_d & {NUM_FACES{solid_q}};
  end

  // open face count of the probed voxel
  always_comb begin
    face_cnt = '0;
    for (int i = 0; i < NUM_FACES; i++) begin
      face_cnt = face_cnt + CNT_W'(faces[i]);
    end
  end

  // lowest pending face and its corner
  always_comb begin
    face_sel = '0;
    for (int i = NUM_FACES - 1; i >= 0; i--) begin
      if (emit_q[i]) begin
        face_sel = FACE_W'(i);
      end
    end
    corner    = CORNER_TAB[face_sel][k_q];
    emit_rest = emit_q & ~(mask_t'(1) << face_sel);
  end

  assign scan_last = (h_q == COORD_W'(CHUNK_SIDE - 1)) && (v_q == COORD_W'(CHUNK_SIDE - 1))
                  && (d_q == COORD_W'(CHUNK_LAYERS - 1));
  assign total_sum = {1'b0, total_q} + (TOTAL_W + 1)'(face_cnt);
  assign slot_free = !out_valid_q || out_ready_i;

  // sequencer next step and datapath control
  always_comb begin
    step_d     = step_q;
    mode_d     = mode_q;
    h_d        = h_q;
    v_d        = v_q;
    d_d        = d_q;
    emit_d     = emit_q;
    k_d        = k_q;
    total_d    = total_q;
    we         = 1'b0;
    in_ready_o = 1'b0;
    push       = 1'b0;
    vx_d       = '0;
    vy_d       = '0;
    vz_d       = '0;
    norm_d     = '0;
    tu_d       = '0;
    tv_d       = 1'b0;
    hv_d       = 1'b0;
    tot_d      = '0;
    last_d     = 1'b0;
    case (ctrl.jmp)
      JMP_NEXT: begin
        step_d = step_q + 1'b1;
      end
      JMP_DISPATCH: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          case (kind_e'(kind_i))
            KIND_LOAD: begin
              we = in_chunk(pos_h_i, pos_v_i, pos_d_i);
            end
            KIND_EMIT: begin
              mode_d = KIND_EMIT;
              h_d    = pos_h_i;
              v_d    = pos_v_i;
              d_d    = pos_d_i;
              step_d = ctrl.tgt;
            end
            KIND_COUNT: begin
              mode_d  = KIND_COUNT;
              h_d     = '0;
              v_d     = '0;
              d_d     = '0;
              total_d = '0;
              step_d  = ctrl.tgt;
            end
            default: begin
              step_d = step_q;
            end
          endcase
        end
      end
      JMP_DECIDE: begin
        if (mode_q == KIND_EMIT) begin
          emit_d = faces;
          k_d    = '0;
          step_d = STEP_EMIT;
        end else begin
          total_d = (total_sum > {1'b0, TOTAL_MAX}) ? TOTAL_MAX : total_sum[TOTAL_W-1:0];
          if (scan_last) begin
            step_d = STEP_RESULT;
          end else begin
            step_d = ctrl.tgt;
            if (h_q == COORD_W'(CHUNK_SIDE - 1)) begin
              h_d = '0;
              if (v_q == COORD_W'(CHUNK_SIDE - 1)) begin
                v_d = '0;
                d_d = d_q + 1'b1;
              end else begin
                v_d = v_q + 1'b1;
              end
            end else begin
              h_d = h_q + 1'b1;
            end
          end
        end
      end
      JMP_EMIT: begin
        if (slot_free) begin
          push = 1'b1;
          if (emit_q == '0) begin
            // empty or enclosed voxel: one blank beat
            last_d = 1'b1;
            step_d = ctrl.tgt;
          end else begin
            vx_d   = VERT_W'(h_q) + VERT_W'(corner[0]);
            vy_d   = VERT_W'(d_q) + VERT_W'(corner[1]);
            vz_d   = VERT_W'(v_q) + VERT_W'(corner[2]);
            norm_d = NORM_W'(face_sel);
            tu_d   = TEXU_W'(type_q) + TEXU_W'(corner[3]);
            tv_d   = corner[4];
            hv_d   = 1'b1;
            if (k_q == CORNER_W'(NUM_CORNERS - 1)) begin
              emit_d = emit_rest;
              k_d    = '0;
              if (emit_rest == '0) begin
                last_d = 1'b1;
                step_d = ctrl.tgt;
              end
            end else begin
              k_d = k_q + 1'b1;
            end
          end
        end
      end
      JMP_RESULT: begin
        if (slot_free) begin
          push   = 1'b1;
          tot_d  = total_q;
          last_d = 1'b1;
          step_d = ctrl.tgt;
        end
      end
      default: begin
        step_d = STEP_IDLE;
      end
    endcase
  end

  assign out_valid_d = push || (out_valid_q && !out_ready_i);

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= STEP_IDLE;
      mode_q      <= KIND_LOAD;
      emit_q      <= '0;
      k_q         <= '0;
      rd_ok_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      step_q      <= step_d;
      mode_q      <= mode_d;
      emit_q      <= emit_d;
      k_q         <= k_d;
      rd_ok_q     <= rd_ok;
      out_valid_q <= out_valid_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    h_q     <= h_d;
    v_q     <= v_d;
    d_q     <= d_d;
    solid_q <= solid_d;
    type_q  <= type_d;
    open_q  <= open_d;
    total_q <= total_d;
    if (push) begin
      vx_q   <= vx_d;
      vy_q   <= vy_d;
      vz_q   <= vz_d;
      norm_q <= norm_d;
      tu_q   <= tu_d;
      tv_q   <= tv_d;
      hv_q   <= hv_d;
      tot_q  <= tot_d;
      last_q <= last_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign vert_x_o      = vx_q;
  assign vert_y_o      = vy_q;
  assign vert_z_o      = vz_q;
  assign normal_code_o = norm_q;
  assign tex_u_o       = tu_q;
  assign tex_v_o       = tv_q;
  assign has_vertex_o  = hv_q;
  assign face_total_o  = tot_q;
  assign last_o        = last_q;

  // a beat without a vertex always closes its request
  a_blank_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !has_vertex_o |-> last_o)
    else $error("blank beat without last");

  // vertex beats carry no face total
  a_vertex_no_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && has_vertex_o |-> face_total_o == '0)
    else $error("vertex beat with face total");

  // pending faces exist only while emitting
  a_emit_mask_scope: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_q != '0 |-> step_q == STEP_EMIT)
    else $error("pending faces outside emit step");

  // decide step branches only to emit, probe or result
  a_decide_branch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q == STEP_DECIDE |=>
      (step_q == STEP_EMIT || step_q == STEP_PROBE || step_q == STEP_RESULT))
    else $error("bad branch from decide step");

endmodule
